// File: design/tpf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Transmit packet framer package
// Shared constants, types and pointer helpers of the transmit packet framer.
// ----------------------------------------------------------------------------
package tpf_pkg;

  localparam int FIFO_DEPTH = 1024;
  localparam int MTU        = 64;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int PTR1_W     = PTR_W + 1;
  localparam int LEN_W      = 16;
  localparam int CMP_W      = LEN_W + 1;
  localparam int CNT_W      = $clog2(MTU + 1);
  localparam int AV_W       = (PTR_W > CNT_W) ? PTR_W : CNT_W;
  localparam int Q_DEPTH    = 4;
  localparam int Q_PTR_W    = $clog2(Q_DEPTH);
  localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);
  localparam int OQ_DEPTH   = 4;
  localparam int OQ_PTR_W   = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_W   = $clog2(OQ_DEPTH + 1);

  typedef logic [PTR_W-1:0] ptr_t;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_DATA  = 2'd1,
    CMD_DRAIN = 2'd2,
    CMD_LINK  = 2'd3
  } cmd_e_t;

  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_BYTE  = 2'd1,
    KIND_EMPTY = 2'd2
  } kind_e_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_RETRY     = 2'd1,
    ST_DROPPED   = 2'd2,
    ST_TOO_LARGE = 2'd3
  } status_e_t;

  typedef enum logic [1:0] {
    E_STATUS = 2'd0,
    E_DRAIN  = 2'd1,
    E_CLEAR  = 2'd2
  } entry_op_t;

  typedef enum logic {
    F_RUN = 1'b0,
    F_HDR = 1'b1
  } front_state_t;

  typedef enum logic {
    B_IDLE  = 1'b0,
    B_DRAIN = 1'b1
  } back_state_t;

  typedef struct packed {
    entry_op_t op;
    status_e_t status;
    logic      kick;
    ptr_t      commit;
  } entry_t;

  typedef struct packed {
    kind_e_t   kind;
    status_e_t status;
    logic [7:0] out_byte;
    logic      last;
    logic      kick;
  } result_t;

  typedef struct packed {
    logic idle;
    logic busy;
    ptr_t rp;
  } back_stat_t;

  function automatic ptr_t ptr_inc(ptr_t p);
    return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic ptr_t ptr_span(ptr_t from, ptr_t to);
    logic [PTR1_W-1:0] d;
    if (to >= from) begin
      d = {1'b0, to} - {1'b0, from};
    end else begin
      d = PTR1_W'(FIFO_DEPTH) - {1'b0, from} + {1'b0, to};
    end
    return d[PTR_W-1:0];
  endfunction

endpackage
`default_nettype wire

// File: design/tx_packet_framer_fifo.sv
`default_nettype none
// Data bytes are taken one per cycle while no header is being written. A drain
// streams one byte per cycle while the result queue has room for the read data.
// A packet start waits until earlier requests have drained, is then decided and
// writes the four header bytes; its status result goes through the command queue.
// Synchronous reset clears all pointers, valid and busy flags and queues at once;
// the ring RAM holds no reset state and needs no clearing pass.
// ----------------------------------------------------------------------------
// Transmit packet framer FIFO
// Ring buffer that frames length-prefixed packets and drains committed bytes.
// ----------------------------------------------------------------------------
module tx_packet_framer_fifo (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  cmd,
  input  logic [15:0] packet_length,
  input  logic [7:0]  data_byte,
  input  logic        link_open,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  kind,
  output logic [1:0]  status,
  output logic [7:0]  out_byte,
  output logic        last,
  output logic        kick
);
  import tpf_pkg::*;

  back_stat_t bstat;
  logic       q_push;
  entry_t     q_in;
  logic       q_full;
  logic       q_empty;
  logic       q_pop;
  entry_t     q_head;
  logic       ram_we;
  ptr_t       ram_waddr;
  logic [7:0] ram_wdata;
  ptr_t       ram_raddr;
  logic [7:0] ram_rdata;
  result_t    res_head;

  assign cfg_ready = 1'b1;

  tpf_front u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .cmd           (cmd),
    .packet_length (packet_length),
    .data_byte     (data_byte),
    .link_open     (link_open),
    .cfg_valid     (cfg_valid),
    .cfg_data      (cfg_data),
    .bstat         (bstat),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_entry       (q_in),
    .ram_we        (ram_we),
    .ram_waddr     (ram_waddr),
    .ram_wdata     (ram_wdata)
  );

  tpf_cmd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .entry_in  (q_in),
    .full      (q_full),
    .empty     (q_empty),
    .pop       (q_pop),
    .entry_out (q_head)
  );

  tpf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_entry   (q_head),
    .q_pop     (q_pop),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .bstat     (bstat),
    .res_pop   (pop),
    .res_empty (empty),
    .res_head  (res_head)
  );

  tpf_ram #(
    .WIDTH (8),
    .DEPTH (FIFO_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign kind     = res_head.kind;
  assign status   = res_head.status;
  assign out_byte = res_head.out_byte;
  assign last     = res_head.last;
  assign kick     = res_head.kick;

endmodule
`default_nettype wire

// File: design/tpf_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tpf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: design/tpf_cmd_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Framer command queue
// Short queue of classified requests between the front end and the drain engine.
// ----------------------------------------------------------------------------
module tpf_cmd_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  tpf_pkg::entry_t entry_in,
  output logic            full,
  output logic            empty,
  input  logic            pop,
  output tpf_pkg::entry_t entry_out
);
  import tpf_pkg::*;

  entry_t             slots [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] count;
  logic               do_push;
  logic               do_pop;

  assign full      = (count == Q_CNT_W'(Q_DEPTH));
  assign empty     = (count == '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && !empty;
  assign entry_out = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= entry_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!do_push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= Q_CNT_W'(Q_DEPTH))
    else $error("command queue count out of range");

endmodule
`default_nettype wire

// File: design/tpf_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Framer front end
// Takes requests, checks packet starts, writes headers and payload bytes.
// ----------------------------------------------------------------------------
module tpf_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic [1:0]          cmd,
  input  logic [15:0]         packet_length,
  input  logic [7:0]          data_byte,
  input  logic                link_open,
  input  logic                cfg_valid,
  input  logic [15:0]         cfg_data,
  input  tpf_pkg::back_stat_t bstat,
  input  logic                q_full,
  output logic                q_push,
  output tpf_pkg::entry_t     q_entry,
  output logic                ram_we,
  output tpf_pkg::ptr_t       ram_waddr,
  output logic [7:0]          ram_wdata
);
  import tpf_pkg::*;

  front_state_t     state;
  front_state_t     state_next;
  logic             held_valid;
  cmd_e_t           held_cmd;
  logic [LEN_W-1:0] held_len;
  logic [7:0]       held_byte;
  logic             held_link;
  logic [15:0]      node_id;
  ptr_t             wp;
  ptr_t             cp;
  logic [LEN_W-1:0] pending;
  logic [31:0]      hdr_word;
  logic [1:0]       hdr_idx;

  logic             consume;
  logic             accept;
  logic             start_go;
  logic [CMP_W-1:0] len_ext;
  logic [CMP_W-1:0] free_sp;
  ptr_t             used;
  status_e_t        start_status;
  logic [31:0]      hdr_shift;

  assign full   = held_valid && !consume;
  assign accept = push && !full;

  assign len_ext   = CMP_W'(held_len) + CMP_W'(4);
  assign used      = ptr_span(bstat.rp, cp);
  assign free_sp   = CMP_W'(FIFO_DEPTH) - CMP_W'(used);
  assign hdr_shift = hdr_word >> {hdr_idx, 3'b000};

  always_comb begin
    if (!held_link || held_len < LEN_W'(2)) begin
      start_status = ST_DROPPED;
    end else if (len_ext >= CMP_W'(FIFO_DEPTH)) begin
      start_status = ST_TOO_LARGE;
    end else if (free_sp <= len_ext) begin
      start_status = ST_RETRY;
    end else begin
      start_status = ST_OK;
    end
  end

  assign start_go = (state == F_RUN) && held_valid && (held_cmd == CMD_START) &&
                    !q_full && bstat.idle;

  always_comb begin
    state_next = state;
    case (state)
      F_RUN: begin
        if (start_go && start_status == ST_OK) begin
          state_next = F_HDR;
        end
      end
      F_HDR: begin
        if (hdr_idx == 2'd3) begin
          state_next = F_RUN;
        end
      end
      default: state_next = F_RUN;
    endcase
  end

  always_comb begin
    consume   = 1'b0;
    q_push    = 1'b0;
    q_entry   = '0;
    ram_we    = 1'b0;
    ram_waddr = wp;
    ram_wdata = held_byte;
    case (state)
      F_RUN: begin
        if (held_valid) begin
          case (held_cmd)
            CMD_START: begin
              consume        = start_go;
              q_push         = start_go;
              q_entry.op     = E_STATUS;
              q_entry.status = start_status;
              q_entry.kick   = (start_status == ST_OK) && !bstat.busy;
              q_entry.commit = cp;
            end
            CMD_DATA: begin
              consume = 1'b1;
              ram_we  = (pending != '0);
            end
            CMD_DRAIN: begin
              consume        = !q_full;
              q_push         = !q_full;
              q_entry.op     = E_DRAIN;
              q_entry.commit = cp;
            end
            CMD_LINK: begin
              consume    = !q_full;
              q_push     = !q_full;
              q_entry.op = E_CLEAR;
            end
            default: consume = 1'b1;
          endcase
        end
      end
      F_HDR: begin
        ram_we    = 1'b1;
        ram_wdata = hdr_shift[7:0];
      end
      default: consume = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_cmd  <= cmd_e_t'(cmd);
      held_len  <= packet_length;
      held_byte <= data_byte;
      held_link <= link_open;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= F_RUN;
      held_valid <= 1'b0;
      node_id    <= '0;
      wp         <= '0;
      cp         <= '0;
      pending    <= '0;
      hdr_idx    <= '0;
      hdr_word   <= '0;
    end else begin
      state      <= state_next;
      held_valid <= accept || (held_valid && !consume);
      if (cfg_valid) begin
        node_id <= cfg_data;
      end
      if (state == F_HDR) begin
        wp      <= ptr_inc(wp);
        hdr_idx <= hdr_idx + 1'b1;
      end else if (consume) begin
        case (held_cmd)
          CMD_START: begin
            wp <= cp;
            if (start_status == ST_OK) begin
              pending  <= held_len;
              hdr_word <= {node_id, held_len - LEN_W'(2)};
              hdr_idx  <= '0;
            end else begin
              pending <= '0;
            end
          end
          CMD_DATA: begin
            if (pending != '0) begin
              wp      <= ptr_inc(wp);
              pending <= pending - 1'b1;
              if (pending == LEN_W'(1)) begin
                cp <= ptr_inc(wp);
              end
            end
          end
          CMD_LINK: begin
            wp      <= '0;
            cp      <= '0;
            pending <= '0;
          end
          default: pending <= pending;
        endcase
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) (pending == '0) |-> (wp == cp))
    else $error("write pointer ahead of commit with no open packet");

  assert property (@(posedge clk) disable iff (rst) (state == F_HDR) |-> (pending != '0))
    else $error("header written without an open packet");

endmodule
`default_nettype wire

// File: design/tpf_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Framer drain engine
// Carries out queued requests, reads committed bytes and queues the results.
// ----------------------------------------------------------------------------
module tpf_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_empty,
  input  tpf_pkg::entry_t     q_entry,
  output logic                q_pop,
  output tpf_pkg::ptr_t       ram_raddr,
  input  logic [7:0]          ram_rdata,
  output tpf_pkg::back_stat_t bstat,
  input  logic                res_pop,
  output logic                res_empty,
  output tpf_pkg::result_t    res_head
);
  import tpf_pkg::*;

  back_state_t         state;
  back_state_t         state_next;
  ptr_t                rp;
  logic [CNT_W-1:0]    cnt;
  logic                busy;
  logic                rd_valid;
  logic                rd_last;
  result_t             oq [OQ_DEPTH];
  logic [OQ_PTR_W-1:0] oq_wr;
  logic [OQ_PTR_W-1:0] oq_rd;
  logic [OQ_CNT_W-1:0] oq_count;

  logic                take;
  logic                issue;
  logic                direct_push;
  result_t             direct_res;
  logic                push;
  result_t             push_res;
  logic                pop_ok;
  ptr_t                avail;
  logic [AV_W-1:0]     avail_w;
  logic [CNT_W-1:0]    run_len;
  logic [OQ_CNT_W:0]   credit_use;

  assign avail      = ptr_span(rp, q_entry.commit);
  assign avail_w    = AV_W'(avail);
  assign run_len    = (avail_w > AV_W'(MTU)) ? CNT_W'(MTU) : CNT_W'(avail_w);
  assign credit_use = (OQ_CNT_W + 1)'(oq_count) + (OQ_CNT_W + 1)'(rd_valid);

  assign take  = (state == B_IDLE) && !rd_valid && !q_empty &&
                 (oq_count < OQ_CNT_W'(OQ_DEPTH));
  assign issue = (state == B_DRAIN) && (credit_use < (OQ_CNT_W + 1)'(OQ_DEPTH));

  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: begin
        if (take && q_entry.op == E_DRAIN && avail != '0) begin
          state_next = B_DRAIN;
        end
      end
      B_DRAIN: begin
        if (issue && cnt == CNT_W'(1)) begin
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    q_pop       = 1'b0;
    ram_raddr   = rp;
    direct_push = 1'b0;
    direct_res  = '0;
    case (state)
      B_IDLE: begin
        q_pop = take;
        if (take) begin
          case (q_entry.op)
            E_STATUS: begin
              direct_push       = 1'b1;
              direct_res.kind   = KIND_START;
              direct_res.status = q_entry.status;
              direct_res.kick   = q_entry.kick;
            end
            E_DRAIN: begin
              direct_push     = (avail == '0);
              direct_res.kind = KIND_EMPTY;
              direct_res.last = 1'b1;
            end
            default: direct_push = 1'b0;
          endcase
        end
      end
      B_DRAIN: q_pop = 1'b0;
      default: q_pop = 1'b0;
    endcase
  end

  always_comb begin
    push     = rd_valid || direct_push;
    push_res = direct_res;
    if (rd_valid) begin
      push_res          = '0;
      push_res.kind     = KIND_BYTE;
      push_res.out_byte = ram_rdata;
      push_res.last     = rd_last;
    end
  end

  assign pop_ok     = res_pop && (oq_count != '0);
  assign res_empty  = (oq_count == '0);
  assign res_head   = oq[oq_rd];
  assign bstat.idle = q_empty && (state == B_IDLE) && !rd_valid;
  assign bstat.busy = busy;
  assign bstat.rp   = rp;

  always_ff @(posedge clk) begin
    if (push) begin
      oq[oq_wr] <= push_res;
    end
    if (issue) begin
      rd_last <= (cnt == CNT_W'(1));
    end
    if (take && q_entry.op == E_DRAIN) begin
      cnt <= run_len;
    end else if (issue) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= B_IDLE;
      rp       <= '0;
      busy     <= 1'b0;
      rd_valid <= 1'b0;
      oq_wr    <= '0;
      oq_rd    <= '0;
      oq_count <= '0;
    end else begin
      state    <= state_next;
      rd_valid <= issue;
      if (take) begin
        case (q_entry.op)
          E_STATUS: begin
            if (q_entry.kick) begin
              busy <= 1'b1;
            end
          end
          E_DRAIN: begin
            if (avail == '0) begin
              busy <= 1'b0;
            end
          end
          E_CLEAR: rp <= '0;
          default: rp <= rp;
        endcase
      end
      if (issue) begin
        rp <= ptr_inc(rp);
      end
      if (push) begin
        oq_wr <= (oq_wr == OQ_PTR_W'(OQ_DEPTH - 1)) ? '0 : oq_wr + 1'b1;
      end
      if (pop_ok) begin
        oq_rd <= (oq_rd == OQ_PTR_W'(OQ_DEPTH - 1)) ? '0 : oq_rd + 1'b1;
      end
      if (push && !pop_ok) begin
        oq_count <= oq_count + 1'b1;
      end else if (!push && pop_ok) begin
        oq_count <= oq_count - 1'b1;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) rd_valid |-> (oq_count < OQ_CNT_W'(OQ_DEPTH)))
    else $error("read data arrives with no room in the result queue");

  assert property (@(posedge clk) disable iff (rst) (state == B_DRAIN) |-> (cnt != '0))
    else $error("drain run active with nothing left to read");

  assert property (@(posedge clk) disable iff (rst) (rd_valid && rd_last) |-> (state == B_IDLE))
    else $error("drain run still active after its final byte");

endmodule
`default_nettype wire

// File: bench/tx_packet_framer_fifo_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Transmit packet framer FIFO testbench
// Drives packet starts, payload bytes, drain requests and link loss through the
// request queue and predicts every result with a behavioral copy of the ring
// buffer. Each popped result is checked field by field against the oldest
// prediction, with random stalls on both sides outside the quiet run and node id changes while idle.
// ----------------------------------------------------------------------------
module tx_packet_framer_fifo_tb;
  import tpf_pkg::*;

  localparam int HDR_BYTES     = 4;
  localparam int MIN_LEN       = 2;
  localparam int SETTLE_CYCLES = 64;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int PRINT_LIMIT   = 40;

  typedef struct {
    cmd_e_t      cmd;
    logic [15:0] len;
    logic [7:0]  dbyte;
    logic        link;
  } request_t;

  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        push          = 1'b0;
  logic        full;
  logic [1:0]  cmd           = 2'd0;
  logic [15:0] packet_length = 16'd0;
  logic [7:0]  data_byte     = 8'd0;
  logic        link_open     = 1'b0;
  logic        cfg_valid     = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data      = 16'd0;
  logic        empty;
  logic        pop           = 1'b0;
  logic [1:0]  kind;
  logic [1:0]  status;
  logic [7:0]  out_byte;
  logic        last;
  logic        kick;

  request_t    pending_requests[$];
  result_t     awaited_results[$];
  request_t    cur_req;

  logic [7:0]  ring_copy [FIFO_DEPTH];
  int unsigned wr_ptr;
  int unsigned commit_ptr;
  int unsigned rd_ptr;
  int unsigned bytes_left;
  bit          tx_busy;
  logic [15:0] node_id_model;

  bit          quiet_run;
  int          send_gap;
  int          recv_gap;
  int          cycle_count;
  int          fail_count;
  int          sent_count;
  int          checked_count;
  int          cfg_writes;
  int          wrap_count;
  int          start_outcomes [4];

  tx_packet_framer_fifo i_dut (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .cmd           (cmd),
    .packet_length (packet_length),
    .data_byte     (data_byte),
    .link_open     (link_open),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .empty         (empty),
    .pop           (pop),
    .kind          (kind),
    .status        (status),
    .out_byte      (out_byte),
    .last          (last),
    .kick          (kick)
  );

  always #5 clk = ~clk;

  function automatic int unsigned ring_next(input int unsigned p);
    return (p + 1 >= FIFO_DEPTH) ? 0 : p + 1;
  endfunction

  function automatic int unsigned ring_fill(input int unsigned from, input int unsigned to);
    return (to >= from) ? to - from : FIFO_DEPTH - from + to;
  endfunction

  task automatic store_byte(input logic [7:0] v);
    ring_copy[wr_ptr[PTR_W-1:0]] = v;
    wr_ptr = ring_next(wr_ptr);
    if (wr_ptr == 0) begin
      wrap_count++;
    end
  endtask

  task automatic frame_request(input request_t r);
    result_t     res;
    int          lenv;
    int unsigned room;
    int unsigned avail;
    int unsigned n;
    logic [15:0] hdr;
    res = '0;
    lenv = int'(r.len);
    case (r.cmd)
      CMD_START: begin
        wr_ptr = commit_ptr;
        bytes_left = 0;
        res.kind = KIND_START;
        room = FIFO_DEPTH - ring_fill(rd_ptr, wr_ptr);
        if (!r.link || lenv < MIN_LEN) begin
          res.status = ST_DROPPED;
        end else if (lenv + HDR_BYTES >= FIFO_DEPTH) begin
          res.status = ST_TOO_LARGE;
        end else if (room <= lenv + HDR_BYTES) begin
          res.status = ST_RETRY;
        end else begin
          hdr = 16'(lenv - MIN_LEN);
          store_byte(hdr[7:0]);
          store_byte(hdr[15:8]);
          store_byte(node_id_model[7:0]);
          store_byte(node_id_model[15:8]);
          bytes_left = lenv;
          res.status = ST_OK;
          res.kick = !tx_busy;
          tx_busy = 1'b1;
        end
        awaited_results.push_back(res);
      end
      CMD_DATA: begin
        if (bytes_left != 0) begin
          store_byte(r.dbyte);
          bytes_left--;
          if (bytes_left == 0) begin
            commit_ptr = wr_ptr;
          end
        end
      end
      CMD_DRAIN: begin
        avail = ring_fill(rd_ptr, commit_ptr);
        if (avail == 0) begin
          tx_busy = 1'b0;
          res.kind = KIND_EMPTY;
          res.last = 1'b1;
          awaited_results.push_back(res);
        end else begin
          n = (avail > MTU) ? MTU : avail;
          for (int unsigned i = 0; i < n; i++) begin
            res.kind = KIND_BYTE;
            res.out_byte = ring_copy[rd_ptr[PTR_W-1:0]];
            res.last = (i + 1 == n);
            rd_ptr = ring_next(rd_ptr);
            awaited_results.push_back(res);
          end
        end
      end
      default: begin
        wr_ptr = 0;
        commit_ptr = 0;
        rd_ptr = 0;
        bytes_left = 0;
      end
    endcase
  endtask

  task automatic report_mismatch(input string what);
    fail_count++;
    if (fail_count <= PRINT_LIMIT) begin
      $display("ERROR at cycle %0d: %s", cycle_count, what);
    end
  endtask

  task automatic check_result();
    result_t want;
    if (awaited_results.size() == 0) begin
      report_mismatch($sformatf("unexpected result kind %0d status %0d byte %02h",
                                kind, status, out_byte));
    end else begin
      want = awaited_results.pop_front();
      checked_count++;
      if (want.kind == KIND_START) begin
        start_outcomes[want.status]++;
      end
      if (kind !== want.kind) begin
        report_mismatch($sformatf("kind %0d, predicted %0d", kind, want.kind));
      end
      if (status !== want.status) begin
        report_mismatch($sformatf("status %0d, predicted %0d", status, want.status));
      end
      if (out_byte !== want.out_byte) begin
        report_mismatch($sformatf("out_byte %02h, predicted %02h", out_byte, want.out_byte));
      end
      if (last !== want.last) begin
        report_mismatch($sformatf("last %0b, predicted %0b", last, want.last));
      end
      if (kick !== want.kick) begin
        report_mismatch($sformatf("kick %0b, predicted %0b", kick, want.kick));
      end
    end
  endtask

  // Request driver.
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
      send_gap = 0;
    end else begin
      if (push && !full) begin
        frame_request(cur_req);
        sent_count++;
      end
      if (!push || !full) begin
        if (send_gap > 0) begin
          send_gap--;
          push <= 1'b0;
        end else if (!quiet_run && $urandom_range(0, 7) == 0) begin
          send_gap = $urandom_range(0, 2);
          push <= 1'b0;
        end else if (pending_requests.size() != 0) begin
          cur_req = pending_requests.pop_front();
          cmd <= cur_req.cmd;
          packet_length <= cur_req.len;
          data_byte <= cur_req.dbyte;
          link_open <= cur_req.link;
          push <= 1'b1;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
      recv_gap = 0;
    end else begin
      if (pop && !empty) begin
        check_result();
      end
      if (recv_gap > 0) begin
        recv_gap--;
        pop <= 1'b0;
      end else if (!quiet_run && $urandom_range(0, 7) == 0) begin
        recv_gap = $urandom_range(0, 2);
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic push_req(input cmd_e_t c, input logic [15:0] l, input logic [7:0] d,
                          input logic lk);
    request_t r;
    r.cmd = c;
    r.len = l;
    r.dbyte = d;
    r.link = lk;
    pending_requests.push_back(r);
  endtask

  task automatic add_packet(input logic [15:0] plen, input int nbytes);
    push_req(CMD_START, plen, 8'($urandom), 1'b1);
    repeat (nbytes) push_req(CMD_DATA, 16'($urandom), 8'($urandom), 1'($urandom));
  endtask

  task automatic add_drains(input int n);
    repeat (n) push_req(CMD_DRAIN, 16'($urandom), 8'($urandom), 1'($urandom));
  endtask

  task automatic add_random_traffic(input int budget);
    int pick;
    int plen;
    int nb;
    while (budget > 0) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        plen = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 80) : $urandom_range(2, 12);
        add_packet(16'(plen), plen);
        budget -= plen + 1;
        if ($urandom_range(0, 1) == 1) begin
          nb = $urandom_range(1, 3);
          add_drains(nb);
          budget -= nb;
        end
      end else if (pick < 75) begin
        add_drains(1);
        budget--;
      end else if (pick < 82) begin
        plen = $urandom_range(2, 12);
        nb = $urandom_range(0, plen - 1);
        add_packet(16'(plen), nb);
        budget -= nb + 1;
      end else if (pick < 87) begin
        case ($urandom_range(0, 2))
          0: push_req(CMD_START, 16'($urandom), 8'($urandom), 1'b0);
          1: push_req(CMD_START, 16'($urandom_range(0, 1)), 8'($urandom), 1'b1);
          default: push_req(CMD_START, 16'($urandom_range(1020, 65535)), 8'($urandom), 1'b1);
        endcase
        budget--;
      end else if (pick < 90) begin
        push_req(CMD_DATA, 16'($urandom), 8'($urandom), 1'($urandom));
      end else if (pick < 93) begin
        push_req(CMD_LINK, 16'($urandom), 8'($urandom), 1'($urandom));
        budget--;
      end else begin
        push_req(CMD_START, 16'($urandom), 8'($urandom), 1'($urandom));
        budget--;
      end
    end
  endtask

  task automatic write_node_id(input logic [15:0] v);
    @(posedge clk);
    cfg_data <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    node_id_model = v;
    cfg_writes++;
    cfg_valid <= 1'b0;
  endtask

  task automatic settle();
    while (pending_requests.size() != 0 || push || awaited_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    wr_ptr = 0;
    commit_ptr = 0;
    rd_ptr = 0;
    bytes_left = 0;
    tx_busy = 1'b0;
    node_id_model = '0;
    quiet_run = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    write_node_id(16'hFFFF);
    add_drains(1);
    push_req(CMD_START, 16'd10, 8'h00, 1'b0);
    push_req(CMD_START, 16'd0, 8'hFF, 1'b1);
    push_req(CMD_START, 16'd1, 8'h00, 1'b1);
    push_req(CMD_START, 16'd1020, 8'h00, 1'b1);
    push_req(CMD_START, 16'hFFFF, 8'hFF, 1'b1);
    push_req(CMD_DATA, 16'hFFFF, 8'hA5, 1'b1);
    push_req(CMD_START, 16'd2, 8'h00, 1'b1);
    push_req(CMD_DATA, 16'h0000, 8'h00, 1'b0);
    push_req(CMD_DATA, 16'hFFFF, 8'hFF, 1'b1);
    push_req(CMD_START, 16'd1014, 8'h00, 1'b1);
    add_packet(16'd1013, 1);
    add_packet(16'd3, 3);
    add_drains(2);
    add_packet(16'd4, 2);
    add_drains(1);
    push_req(CMD_LINK, 16'hFFFF, 8'hFF, 1'b1);
    add_packet(16'd1019, 0);
    push_req(CMD_LINK, 16'h0000, 8'h00, 1'b0);
    add_drains(1);
    settle();

    write_node_id(16'($urandom));
    add_random_traffic(57);
    settle();
    write_node_id(16'h8001);
    add_random_traffic(57);
    settle();
    write_node_id(16'h7FFE);
    add_random_traffic(57);
    settle();

    quiet_run = 1'b1;
    write_node_id(16'($urandom));
    add_random_traffic(57);
    add_drains(4);
    settle();

    $display("Summary: %0d requests, %0d results checked, %0d node id writes, %0d ring wraps.",
             sent_count, checked_count, cfg_writes, wrap_count);
    $display("Start outcomes: %0d accepted, %0d retry, %0d dropped, %0d too large.",
             start_outcomes[ST_OK], start_outcomes[ST_RETRY], start_outcomes[ST_DROPPED],
             start_outcomes[ST_TOO_LARGE]);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: sim.f
design/tpf_pkg.sv
design/tpf_ram.sv
design/tpf_cmd_queue.sv
design/tpf_front.sv
design/tpf_back.sv
design/tx_packet_framer_fifo.sv
bench/tx_packet_framer_fifo_tb.sv
